// File: rtl/assert_macros.svh
// Assertion macros shared by the cache RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DMC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define DMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: rtl/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache.
// No dependencies; used by dmc_line_ram and direct_mapped_cache.
package dmc_pkg;

  localparam int LINE_COUNT   = 16;   // power of two
  localparam int ADDRESS_BITS = 16;
  localparam int INDEX_BITS   = $clog2(LINE_COUNT);
  localparam int TAG_BITS     = ADDRESS_BITS - INDEX_BITS;
  localparam int WORD_BITS    = 32;
  localparam int COUNT_BITS   = 32;
  localparam int FETCH_SCALE  = 10;   // stand-in memory returns address * 10

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    tag_t  tag;
    word_t word;
  } line_t;

  typedef struct packed {
    logic   en;
    index_t idx;
    line_t  line;
  } line_wr_t;

endpackage

// File: rtl/dmc_line_ram.sv
// Tag and data store: one line per entry, one write and one registered read per cycle.
// Depends on dmc_pkg.
module dmc_line_ram (
  input  logic              clk,
  input  dmc_pkg::index_t   rd_idx,
  input  dmc_pkg::line_wr_t wr,
  output dmc_pkg::line_t    rd_line
);

  dmc_pkg::line_t mem [dmc_pkg::LINE_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.line;
    end
  end

  always_ff @(posedge clk) begin
    rd_line <= mem[rd_idx];
  end

endmodule

// File: rtl/direct_mapped_cache.sv
// Direct-mapped cache, 16 one-word lines, with saturating hit/miss counters.
// The input transfer starts the registered tag/data RAM read; the lookup state then
// compares, writes back and registers the result. The RAM read then compare/write-back
// of the same line serializes accesses. A stalled result holds the lookup.
// Reset (rst, synchronous): line valid bits and counters clear at once; no sweep.
// Depends on dmc_pkg, dmc_line_ram and assert_macros.svh.
`include "assert_macros.svh"

module direct_mapped_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] address,
  input  logic [31:0] store_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] line_data,
  output logic [31:0] hits_so_far,
  output logic [31:0] misses_so_far
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_LOOKUP = 1'b1;

  logic state;
  logic accept;
  logic advance;

  logic                                 op_q;
  logic [dmc_pkg::ADDRESS_BITS-1:0]     addr_q;
  dmc_pkg::word_t                       wdata_q;
  dmc_pkg::index_t                      idx_q;
  dmc_pkg::tag_t                        tag_q;

  logic [dmc_pkg::LINE_COUNT-1:0]       line_valid;
  dmc_pkg::count_t                      hit_total;
  dmc_pkg::count_t                      miss_total;

  dmc_pkg::line_t                       rd_line;
  dmc_pkg::line_wr_t                    wr;
  logic                                 line_hit;
  dmc_pkg::word_t                       fetch_word;
  dmc_pkg::word_t                       word_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign advance  = (state == S_LOOKUP) && (!out_valid || out_ready);

  assign idx_q = addr_q[dmc_pkg::INDEX_BITS-1:0];
  assign tag_q = addr_q[dmc_pkg::ADDRESS_BITS-1:dmc_pkg::INDEX_BITS];

  // While a lookup waits on the output, keep re-reading the held line.
  dmc_line_ram u_ram (
    .clk     (clk),
    .rd_idx  ((state == S_IDLE) ? address[dmc_pkg::INDEX_BITS-1:0] : idx_q),
    .wr      (wr),
    .rd_line (rd_line)
  );

  assign line_hit   = line_valid[idx_q] && (rd_line.tag == tag_q);
  assign fetch_word = dmc_pkg::WORD_BITS'(addr_q) *
                      dmc_pkg::WORD_BITS'(dmc_pkg::FETCH_SCALE);

  always_comb begin
    if (op_q == dmc_pkg::OP_WRITE) begin
      word_next = wdata_q;
    end else if (line_hit) begin
      word_next = rd_line.word;
    end else begin
      word_next = fetch_word;
    end
  end

  // Write-back of the looked-up line; a read hit rewrites the same contents.
  always_comb begin
    wr.en        = advance;
    wr.idx       = idx_q;
    wr.line.tag  = tag_q;
    wr.line.word = word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (accept)  state <= S_LOOKUP;
        S_LOOKUP: if (advance) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= operation;
      addr_q  <= address;
      wdata_q <= store_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      hit_total  <= '0;
      miss_total <= '0;
    end else if (advance) begin
      line_valid[idx_q] <= 1'b1;
      if (line_hit) begin
        if (hit_total != '1) hit_total <= hit_total + 1'b1;
      end else begin
        if (miss_total != '1) miss_total <= miss_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Counters in the result show the value after this access.
  always_ff @(posedge clk) begin
    if (advance) begin
      hit       <= line_hit;
      line_data <= word_next;
      hits_so_far <= (line_hit && hit_total != '1) ? hit_total + 1'b1 : hit_total;
      misses_so_far <= (!line_hit && miss_total != '1) ? miss_total + 1'b1 : miss_total;
    end
  end

  `DMC_ASSERT_NEXT(a_accept_to_lookup, clk, rst, accept, state == S_LOOKUP)
  `DMC_ASSERT_NEXT(a_lookup_gives_result, clk, rst, advance, out_valid && line_valid[idx_q])
  `DMC_ASSERT_NOW(a_lookup_blocks_input, clk, rst, state == S_LOOKUP, !in_ready)
  `DMC_ASSERT_NEXT(a_counts_monotonic, clk, rst, 1'b1,
                   hit_total >= $past(hit_total) && miss_total >= $past(miss_total))

endmodule
